// File: design/lifo_stack_with_reverse_unit_defines.svh
// ----------------------------------------------------------------------------
// LIFO stack assertion macros
// Shared property templates for the stack's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_REVERSE_UNIT_DEFINES_SVH
`define LIFO_STACK_WITH_REVERSE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LSR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lsr_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack package
// Sizes, operation and status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsr_pkg;

    // Storage depth and derived widths.
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int WORD_W = 32;

    localparam logic [CNT_W-1:0] DEFAULT_LIMIT = CNT_W'(5);
    localparam logic [CNT_W-1:0] DEPTH_CNT     = CNT_W'(DEPTH);

    // Request operations.
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_PEEK    = 2'd2,
        OP_REVERSE = 2'd3
    } lsr_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } lsr_status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SWAP_RD,
        S_SWAP_WH,
        S_SWAP_WL
    } lsr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // request taken this cycle
        logic load_now;   // result complete at acceptance
        logic load_late;  // result completes after a read or a reverse
        logic late_read;  // late result carries the read word
        logic rd_en;      // capture memory read data
        logic rd_swap;    // read at the swap pointers rather than the top
        logic wr_hi;      // write the lower word to the upper slot
        logic wr_lo;      // write the upper word to the lower slot
    } lsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_zero;  // no words stored
        logic fill_multi; // two or more words stored
        logic swap_last;  // current swap pair is the final one
        logic out_busy;   // output word held and stalled
    } lsr_sts_t;

endpackage

// File: design/lifo_stack_with_reverse_unit.sv
// ----------------------------------------------------------------------------
// LIFO stack with reverse
// Top level: controller and datapath of a sixteen-word stack of signed words.
// ----------------------------------------------------------------------------
// A push, a refused push, a pop or peek of an empty stack, and a reverse of
// fewer than two words complete at acceptance. A pop or peek of a stored word
// passes through a read state, as the word memory has registered read data. A
// reverse reads each pair together and then writes it back, upper slot first,
// through the memory's single write port. One request is in progress at a
// time; the result sits in an output register, and the next word is taken as
// soon as that register is free or being emptied. The storage needs no
// clearing after reset. The limit register is always ready and should be
// written only while the block is idle.
module lifo_stack_with_reverse_unit
    import lsr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               req_type,
    input  logic signed [WORD_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] read_value,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         occupancy,
    output logic                     empty_flag,
    output logic                     full_flag,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         cfg_data
);

    lsr_cmd_t cmd;
    lsr_sts_t sts;

    // The limit register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    lsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .push_value (push_value),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .read_value (read_value),
        .status     (status),
        .occupancy  (occupancy),
        .empty_flag (empty_flag),
        .full_flag  (full_flag),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// File: design/lsr_ctrl.sv
// ----------------------------------------------------------------------------
// LIFO stack controller
// Sequences each request: operations that complete at acceptance, the
// top-of-stack read and the read, write, write loop that reverses the stack.
// ----------------------------------------------------------------------------
module lsr_ctrl
    import lsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  lsr_sts_t   sts,
    output lsr_cmd_t   cmd
);

    lsr_state_t state_reg;
    lsr_state_t state_next;
    logic       accept;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new word is taken only when idle and the output register can move.
    assign in_stall = (state_reg != S_IDLE) || sts.out_busy;
    assign accept   = in_valid && !in_stall;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.rd_en = 1'b1;
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    case (lsr_op_t'(req_type))
                        OP_POP, OP_PEEK:
                        begin
                            if (sts.fill_zero)
                            begin
                                cmd.load_now = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (sts.fill_multi)
                            begin
                                state_next = S_SWAP_RD;
                            end
                            else
                            begin
                                cmd.load_now = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.load_now = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.load_late = 1'b1;
                cmd.late_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_SWAP_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_swap = 1'b1;
                state_next  = S_SWAP_WH;
            end
            S_SWAP_WH:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = S_SWAP_WL;
            end
            S_SWAP_WL:
            begin
                cmd.wr_lo = 1'b1;
                if (sts.swap_last)
                begin
                    cmd.load_late = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_SWAP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/lsr_datapath.sv
// ----------------------------------------------------------------------------
// LIFO stack datapath
// Word memory, fill count, limit register, swap pointers and the output
// register, all driven by the controller's commands.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_reverse_unit_defines.svh"

module lsr_datapath
    import lsr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [1:0]               req_type,
    input  logic signed [WORD_W-1:0] push_value,
    input  logic                     cfg_valid,
    input  logic [CNT_W-1:0]         cfg_data,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic signed [WORD_W-1:0] read_value,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         occupancy,
    output logic                     empty_flag,
    output logic                     full_flag,
    input  lsr_cmd_t                 cmd,
    output lsr_sts_t                 sts
);

    logic [WORD_W-1:0] word_store [DEPTH];

    logic [CNT_W-1:0]  stack_limit_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [ADDR_W-1:0] lo_reg;
    logic [ADDR_W-1:0] hi_reg;
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] read_value_reg;
    logic [1:0]               status_reg;
    logic [CNT_W-1:0]         occupancy_reg;
    logic                     empty_flag_reg;
    logic                     full_flag_reg;

    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  top_sum;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] hi_start;
    logic [ADDR_W-1:0] ptr_gap;
    logic              can_push;
    logic              is_push;
    logic              is_pop;
    logic              is_rev;

    logic [WORD_W-1:0] res_value;
    lsr_status_t       res_status;
    logic [CNT_W-1:0]  res_occ;
    logic              res_load;

    // Effective limit: zero selects the default, anything above depth is capped.
    always_comb
    begin
        if (stack_limit_reg == '0)
        begin
            lim = DEFAULT_LIMIT;
        end
        else if (stack_limit_reg > DEPTH_CNT)
        begin
            lim = DEPTH_CNT;
        end
        else
        begin
            lim = stack_limit_reg;
        end
    end

    // Request decode and addresses.
    assign is_push  = (lsr_op_t'(req_type) == OP_PUSH);
    assign is_pop   = (lsr_op_t'(req_type) == OP_POP);
    assign is_rev   = (lsr_op_t'(req_type) == OP_REVERSE);
    assign can_push = (fill_count_reg < lim);
    assign top_sum  = fill_count_reg - CNT_W'(1);
    assign top_addr = top_sum[ADDR_W-1:0];
    assign hi_start = top_sum[ADDR_W-1:0];
    assign ptr_gap  = hi_reg - lo_reg;

    assign sts.fill_zero  = (fill_count_reg == '0);
    assign sts.fill_multi = (fill_count_reg > CNT_W'(1));
    assign sts.swap_last  = (ptr_gap <= ADDR_W'(2));
    assign sts.out_busy   = out_valid_reg && out_stall;

    // Limit register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_limit_reg <= DEFAULT_LIMIT;
        end
        else if (cfg_valid)
        begin
            stack_limit_reg <= cfg_data;
        end
    end

    // Fill count follows accepted pushes and pops.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (cmd.accept && is_push && can_push)
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        else if (cmd.accept && is_pop && !sts.fill_zero)
        begin
            fill_count_next = top_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // Swap pointers walk inwards from both ends.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_rev)
        begin
            lo_reg <= '0;
            hi_reg <= hi_start;
        end
        else if (cmd.wr_lo)
        begin
            lo_reg <= lo_reg + ADDR_W'(1);
            hi_reg <= hi_reg - ADDR_W'(1);
        end
    end

    // Word memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_push && can_push)
        begin
            word_store[fill_count_reg[ADDR_W-1:0]] <= push_value;
        end
        else if (cmd.wr_hi)
        begin
            word_store[hi_reg] <= rd_a_reg;
        end
        else if (cmd.wr_lo)
        begin
            word_store[lo_reg] <= rd_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_a_reg <= word_store[cmd.rd_swap ? lo_reg : top_addr];
            rd_b_reg <= word_store[hi_reg];
        end
    end

    // Result fields, either complete at acceptance or after the read or reverse.
    always_comb
    begin
        res_value  = '0;
        res_status = ST_OK;
        res_occ    = fill_count_reg;
        res_load   = cmd.load_now || cmd.load_late;
        if (cmd.load_late)
        begin
            res_value = cmd.late_read ? rd_a_reg : '0;
        end
        else
        begin
            case (lsr_op_t'(req_type))
                OP_PUSH:
                begin
                    if (can_push)
                    begin
                        res_occ = fill_count_next;
                    end
                    else
                    begin
                        res_status = ST_FULL;
                    end
                end
                OP_POP:
                begin
                    res_value  = '1;
                    res_status = ST_EMPTY;
                end
                OP_PEEK:
                begin
                    res_status = ST_EMPTY;
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // Output register: valid is cleared when the word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            read_value_reg <= res_value;
            status_reg     <= res_status;
            occupancy_reg  <= res_occ;
            empty_flag_reg <= (res_occ == '0);
            full_flag_reg  <= (res_occ >= lim);
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign occupancy  = occupancy_reg;
    assign empty_flag = empty_flag_reg;
    assign full_flag  = full_flag_reg;

    // Checks on the datapath's own bookkeeping.
    `LSR_ASSERT_NOW(a_fill_in_range, 1'b1, fill_count_reg <= DEPTH_CNT, "fill count above depth")
    `LSR_ASSERT_NOW(a_no_overwrite, sts.out_busy, !res_load, "held output word overwritten")
    `LSR_ASSERT_NEXT(a_pop_decrements, cmd.accept && is_pop && !sts.fill_zero,
        fill_count_reg == $past(top_sum), "pop did not remove the top word")
    `LSR_ASSERT_NOW(a_swap_order, cmd.wr_hi || cmd.wr_lo, hi_reg > lo_reg,
        "swap pointers crossed")

endmodule

// File: test/tb_lifo_stack_with_reverse_unit.sv
// ----------------------------------------------------------------------------
// LIFO stack with reverse: regression testbench
// Drives push, pop, peek and reverse requests through the request channel
// under random source gaps and result stalls. A shadow copy of the stack
// predicts every result, and each returned word is checked field by field
// against the oldest prediction. The limit register is reprogrammed between
// phases while the block is quiet, covering zero, one, the full depth and
// values above the depth.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_reverse_unit
    import lsr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned SETTLE_CYCLES = 32;

    // One predicted result word.
    typedef struct {
        logic [WORD_W-1:0] read_value;
        lsr_status_t       status;
        logic [CNT_W-1:0]  occupancy;
        logic              empty_flag;
        logic              full_flag;
    } stack_reply_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic [1:0]               req_type   = OP_PUSH;
    logic signed [WORD_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         occupancy;
    logic                     empty_flag;
    logic                     full_flag;
    logic                     cfg_valid  = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data   = '0;

    // Shadow stack and limit register.
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int unsigned       shadow_fill  = 0;
    logic [CNT_W-1:0]  shadow_limit = DEFAULT_LIMIT;

    stack_reply_t stack_replies_q[$];
    int unsigned  fault_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  gap_pct     = 0;
    int unsigned  stall_pct   = 0;

    lifo_stack_with_reverse_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .occupancy  (occupancy),
        .empty_flag (empty_flag),
        .full_flag  (full_flag),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Effective capacity: zero selects the default, and the depth caps it.
    function automatic int unsigned usable_entries();
        int unsigned lim;
        lim = (shadow_limit == '0) ? int'(DEFAULT_LIMIT) : int'(shadow_limit);
        if (lim > DEPTH)
            lim = DEPTH;
        return lim;
    endfunction

    // Applies one request to the shadow stack and returns the result it gives.
    function automatic stack_reply_t apply_stack_op(input lsr_op_t op,
                                                    input logic [WORD_W-1:0] word);
        stack_reply_t      reply;
        int unsigned       lim;
        logic [WORD_W-1:0] held;
        lim = usable_entries();
        reply.read_value = '0;
        reply.status     = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (shadow_fill < lim)
                begin
                    shadow_words[shadow_fill] = word;
                    shadow_fill++;
                end
                else
                    reply.status = ST_FULL;
            end
            OP_POP:
            begin
                if (shadow_fill == 0)
                begin
                    reply.read_value = '1;
                    reply.status     = ST_EMPTY;
                end
                else
                begin
                    shadow_fill--;
                    reply.read_value = shadow_words[shadow_fill];
                end
            end
            OP_PEEK:
            begin
                if (shadow_fill == 0)
                    reply.status = ST_EMPTY;
                else
                    reply.read_value = shadow_words[shadow_fill - 1];
            end
            default:
            begin
                for (int unsigned i = 0; i < shadow_fill / 2; i++)
                begin
                    held = shadow_words[shadow_fill - 1 - i];
                    shadow_words[shadow_fill - 1 - i] = shadow_words[i];
                    shadow_words[i] = held;
                end
            end
        endcase
        reply.occupancy  = CNT_W'(shadow_fill);
        reply.empty_flag = (shadow_fill == 0);
        reply.full_flag  = (shadow_fill >= lim);
        return reply;
    endfunction

    // Random data word, leaning on the extremes now and then.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Sends one request word, with an optional gap before it. Valid is left
    // high so that back-to-back words need no second assignment.
    task automatic send_request(input lsr_op_t op, input logic [WORD_W-1:0] word);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= op;
        push_value <= word;
        do
            @(posedge clk);
        while (in_stall);
        stack_replies_q.push_back(apply_stack_op(op, word));
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (stack_replies_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes the limit register once the block has gone quiet.
    task automatic write_limit(input logic [CNT_W-1:0] value);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        shadow_limit  = value;
    endtask

    // Pop, peek and reverse of an empty stack.
    task automatic test_empty_stack();
        send_request(OP_POP, random_word());
        send_request(OP_PEEK, random_word());
        send_request(OP_REVERSE, random_word());
    endtask

    // Fills the default capacity with extreme words, overflows it, then peeks, reverses, pops and reverses again.
    task automatic test_push_extremes();
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 32'h0000_0001);
        send_request(OP_PUSH, 32'h5A5A_A5A5);
        send_request(OP_PEEK, random_word());
        send_request(OP_REVERSE, random_word());
        send_request(OP_POP, random_word());
        send_request(OP_REVERSE, random_word());
    endtask

    // Lowers the limit below the stored count, then empties the stack,
    // reversing a single word on the way.
    task automatic test_limit_below_fill();
        write_limit(CNT_W'(2));
        send_request(OP_PUSH, random_word());
        send_request(OP_PEEK, random_word());
        send_request(OP_POP, random_word());
        send_request(OP_POP, random_word());
        send_request(OP_POP, random_word());
        send_request(OP_REVERSE, random_word());
        send_request(OP_POP, random_word());
        write_limit(CNT_W'(0));
    endtask

    // Random traffic in tides: push-heavy until full, then pop-heavy until
    // empty, with peeks and reverses throughout.
    task automatic run_stack_tide(input int unsigned count);
        lsr_op_t     op;
        int unsigned roll;
        logic        filling;
        filling = 1'b1;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (filling)
                op = lsr_op_t'((roll < 60) ? OP_PUSH : (roll < 75) ? OP_POP :
                               (roll < 90) ? OP_PEEK : OP_REVERSE);
            else
                op = lsr_op_t'((roll < 60) ? OP_POP : (roll < 75) ? OP_PUSH :
                               (roll < 90) ? OP_PEEK : OP_REVERSE);
            send_request(op, random_word());
            if (filling && shadow_fill >= usable_entries() && $urandom_range(2) == 0)
                filling = 1'b0;
            else if (!filling && shadow_fill == 0 && $urandom_range(2) == 0)
                filling = 1'b1;
        end
    endtask

    // Phases over a spread of limits, the stack contents carried across.
    task automatic test_random_traffic();
        logic [CNT_W-1:0] limits [14];
        limits = '{CNT_W'(16), CNT_W'(1), CNT_W'(0), CNT_W'(31), CNT_W'(2),
                   CNT_W'(8), CNT_W'(17), CNT_W'(3), CNT_W'(16), CNT_W'(4),
                   CNT_W'(15), CNT_W'(1), CNT_W'(5), CNT_W'(0)};
        foreach (limits[i])
        begin
            write_limit((i == 9) ? CNT_W'($urandom_range(31)) : limits[i]);
            case ($urandom_range(2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 40;
            endcase
            run_stack_tide(100);
        end
    endtask

    // Full-rate stream at the full depth with no idling on either side.
    task automatic test_steady_stream();
        gap_pct   = 0;
        stall_pct = 0;
        write_limit(CNT_W'(16));
        run_stack_tide(130);
    endtask

    // Result stalls in random bursts.
    always
    begin
        @(posedge clk);
        if (rst_n && stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Checks each accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        stack_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (stack_replies_q.size() == 0)
            begin
                $error("result word with no request outstanding");
                fault_count++;
            end
            else
            begin
                want = stack_replies_q.pop_front();
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(want.read_value), read_value);
                    fault_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fault_count++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                    fault_count++;
                end
                if (empty_flag !== want.empty_flag)
                begin
                    $error("empty_flag: expected %0b, got %0b", want.empty_flag, empty_flag);
                    fault_count++;
                end
                if (full_flag !== want.full_flag)
                begin
                    $error("full_flag: expected %0b, got %0b", want.full_flag, full_flag);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_push_extremes();
        test_limit_below_fill();
        test_random_traffic();
        test_steady_stream();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && stack_replies_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: lifo_stack_with_reverse_unit.f
+incdir+design
design/lsr_pkg.sv
design/lsr_ctrl.sv
design/lsr_datapath.sv
design/lifo_stack_with_reverse_unit.sv
test/tb_lifo_stack_with_reverse_unit.sv
